/* rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and codes of the pressure projection solver: request and
// result codes, register indexes, controller states, command and status.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int OP_W        = 2;
	localparam int IDX_W       = 10;
	localparam int DATA_W      = 32;
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 96;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 31;
	localparam int GRID_REG_W  = 6;
	localparam int ITER_REG_W  = 8;
	localparam int OVR_REG_W   = 18;
	localparam int SCALE_REG_W = 31;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	localparam logic [KIND_W-1:0] KIND_FLUID = 2'd0;

	localparam logic RES_READ  = 1'b0;
	localparam logic RES_SOLVE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_RELAXATION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SCALE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REST_DENSITY    = 3'd5;

	typedef enum logic [2:0] {
		NB_C,
		NB_L,
		NB_R,
		NB_B,
		NB_T
	} nb_sel_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_INIT_CLR,
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_READ_OUT,
		ST_CLEAR,
		ST_SWEEP,
		ST_CELL_RC,
		ST_CELL_RL,
		ST_CELL_RR,
		ST_CELL_RB,
		ST_CELL_RT,
		ST_CELL_CAP,
		ST_CHECK,
		ST_ABS,
		ST_MUL,
		ST_DIVIDE,
		ST_CORR,
		ST_PMUL,
		ST_PSHIFT,
		ST_WR1,
		ST_WR2,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    load_wr;
		logic    rd_req;
		logic    read_out;
		logic    fin_out;
		logic    clr_start;
		logic    clr_full;
		logic    clr_wr;
		logic    sweep_start;
		logic    cell_next;
		nb_sel_t rd_sel;
		logic    cap_en;
		nb_sel_t cap_sel;
		logic    calc_div;
		logic    calc_abs;
		logic    mul;
		logic    div_step;
		logic    corr_calc;
		logic    pmul;
		logic    pshift;
		logic    wr1;
		logic    wr2;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic clr_empty;
		logic sweep_empty;
		logic cell_last;
		logic skip;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

/* rtl/pressure_projection_solver.sv */
// ----------------------------------------------------------------------------
// pressure_projection_solver
// Gauss-Seidel pressure projection over a grid of cells held in on-chip RAM.
// ----------------------------------------------------------------------------
// One request at a time; a read waits for the result port to be free. A solve
// first clears the pressures of the w*h cells, then visits each interior cell
// once per iteration and skips or updates it; the five neighbour reads share
// one read port of the cell RAMs and the correction passes through a
// bit-serial divider of 34 steps. After reset the pressure RAM is cleared,
// during which no request is taken.
module pressure_projection_solver import pps_pkg::*; #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// cell_index, velocity_x_in, velocity_y_in, density_in, open_in, kind_in
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [OP_W-1:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// pressure_out, velocity_x_out, velocity_y_out
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic                   m_axis_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cmd_t  cmd;
	stat_t st;

	pps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.op       (s_axis_tuser),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.st       (st)
	);

	pps_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_kind  (m_axis_tuser),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.read_out || cmd.fin_out) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result loaded over a pending result");

	a_clr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !s_axis_tready)
		else $error("request taken during pressure clearing");

	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_wr, cmd.clr_wr, cmd.wr1, cmd.wr2}))
		else $error("conflicting RAM write sources");
`endif

endmodule

/* rtl/pps_ram.sv */
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl
// Controller of the solver: sequences load, read and solve requests and the
// per-cell steps of a sweep, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] op,
	output logic            in_ready,
	output cmd_t            cmd,
	input  stat_t           st
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:     state_d = ST_INIT_CLR;
			ST_INIT_CLR: if (st.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_LOAD:  state_d = ST_LOAD;
						OP_SOLVE: state_d = ST_CLEAR;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD:     state_d = ST_IDLE;
			ST_READ:     state_d = ST_READ_OUT;
			ST_READ_OUT: if (st.out_free) state_d = ST_IDLE;
			ST_CLEAR:    if (st.clr_empty || st.clr_last) state_d = ST_SWEEP;
			ST_SWEEP:    state_d = st.sweep_empty ? ST_DONE : ST_CELL_RC;
			ST_CELL_RC:  state_d = ST_CELL_RL;
			ST_CELL_RL:  state_d = ST_CELL_RR;
			ST_CELL_RR:  state_d = ST_CELL_RB;
			ST_CELL_RB:  state_d = ST_CELL_RT;
			ST_CELL_RT:  state_d = ST_CELL_CAP;
			ST_CELL_CAP: state_d = ST_CHECK;
			ST_CHECK:    state_d = st.skip ? ST_NEXT : ST_ABS;
			ST_ABS:      state_d = ST_MUL;
			ST_MUL:      state_d = ST_DIVIDE;
			ST_DIVIDE:   if (st.div_last) state_d = ST_CORR;
			ST_CORR:     state_d = ST_PMUL;
			ST_PMUL:     state_d = ST_PSHIFT;
			ST_PSHIFT:   state_d = ST_WR1;
			ST_WR1:      state_d = ST_WR2;
			ST_WR2:      state_d = ST_NEXT;
			ST_NEXT:     state_d = st.cell_last ? ST_DONE : ST_CELL_RC;
			ST_DONE:     if (st.out_free) state_d = ST_IDLE;
			default:     state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel  = NB_C;
		cmd.cap_sel = NB_C;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_start = 1'b1;
				cmd.clr_full  = 1'b1;
			end
			ST_INIT_CLR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture   = 1'b1;
					cmd.clr_start = (op == OP_SOLVE);
				end
			end
			ST_LOAD: cmd.load_wr = 1'b1;
			ST_READ: cmd.rd_req = 1'b1;
			ST_READ_OUT: begin
				cmd.rd_req   = 1'b1;
				cmd.read_out = st.out_free;
			end
			ST_CLEAR: cmd.clr_wr = !st.clr_empty;
			ST_SWEEP: cmd.sweep_start = 1'b1;
			ST_CELL_RC: cmd.rd_sel = NB_C;
			ST_CELL_RL: begin
				cmd.rd_sel  = NB_L;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_C;
			end
			ST_CELL_RR: begin
				cmd.rd_sel  = NB_R;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_L;
			end
			ST_CELL_RB: begin
				cmd.rd_sel  = NB_B;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_R;
			end
			ST_CELL_RT: begin
				cmd.rd_sel  = NB_T;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_B;
			end
			ST_CELL_CAP: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_T;
			end
			ST_CHECK:  cmd.calc_div  = 1'b1;
			ST_ABS:    cmd.calc_abs  = 1'b1;
			ST_MUL:    cmd.mul       = 1'b1;
			ST_DIVIDE: cmd.div_step  = 1'b1;
			ST_CORR:   cmd.corr_calc = 1'b1;
			ST_PMUL:   cmd.pmul      = 1'b1;
			ST_PSHIFT: cmd.pshift    = 1'b1;
			ST_WR1:    cmd.wr1       = 1'b1;
			ST_WR2:    cmd.wr2       = 1'b1;
			ST_NEXT:   cmd.cell_next = 1'b1;
			ST_DONE:   cmd.fin_out   = st.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

/* rtl/pps_dpath.sv */
// ----------------------------------------------------------------------------
// pps_dpath
// Datapath of the solver: configuration registers, cell memories, sweep
// counters, the cell update arithmetic and the result register.
// ----------------------------------------------------------------------------
module pps_dpath import pps_pkg::*; #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [IN_TDATA_W-1:0]  in_data,
	input  cmd_t                   cmd,
	output stat_t                  st,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   out_kind,
	output logic [OUT_TDATA_W-1:0] out_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int QW    = 34;
	localparam int DCW   = $clog2(QW);
	localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [49:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// configuration
	logic [GRID_REG_W-1:0]  grid_w_q, grid_h_q;
	logic [ITER_REG_W-1:0]  iter_cnt_q;
	logic [OVR_REG_W-1:0]   ovr_q;
	logic [SCALE_REG_W-1:0] pscale_q, rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q   <= GRID_REG_W'(32);
			grid_h_q   <= GRID_REG_W'(32);
			iter_cnt_q <= ITER_REG_W'(40);
			ovr_q      <= OVR_REG_W'(124518);
			pscale_q   <= SCALE_REG_W'(65536);
			rest_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:      grid_w_q   <= cfg_wdata[GRID_REG_W-1:0];
				CFG_GRID_HEIGHT:     grid_h_q   <= cfg_wdata[GRID_REG_W-1:0];
				CFG_ITERATION_COUNT: iter_cnt_q <= cfg_wdata[ITER_REG_W-1:0];
				CFG_OVER_RELAXATION: ovr_q      <= cfg_wdata[OVR_REG_W-1:0];
				CFG_PRESSURE_SCALE:  pscale_q   <= cfg_wdata[SCALE_REG_W-1:0];
				CFG_REST_DENSITY:    rest_q     <= cfg_wdata[SCALE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	logic [XW-1:0] w_eff, w_m2;
	logic [YW-1:0] h_eff, h_m2;
	logic [AW-1:0] h_aw;

	assign w_eff = (int'(grid_w_q) > MAX_WIDTH)  ? XW'(MAX_WIDTH)  : XW'(grid_w_q);
	assign h_eff = (int'(grid_h_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(grid_h_q);
	assign w_m2  = w_eff - XW'(2);
	assign h_m2  = h_eff - YW'(2);
	assign h_aw  = AW'(h_eff);

	// request
	logic [IDX_W-1:0]         idx_q;
	logic signed [DATA_W-1:0] vxin_q, vyin_q, densin_q;
	logic                     openin_q;
	logic [KIND_W-1:0]        kindin_q;
	logic                     idx_ok;
	logic [AW-1:0]            addr_idx;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q    <= in_data[9:0];
			vxin_q   <= in_data[41:10];
			vyin_q   <= in_data[73:42];
			densin_q <= in_data[105:74];
			openin_q <= in_data[106];
			kindin_q <= in_data[108:107];
		end
	end

	assign idx_ok   = int'(idx_q) < DEPTH;
	assign addr_idx = AW'(idx_q);

	// clearing and sweep counters
	logic [CW-1:0]       clr_q, clr_n_q;
	logic [XW+YW-1:0]    wh;
	logic [ITER_REG_W-1:0] iter_q;
	logic [XW-1:0]       x_q;
	logic [YW-1:0]       y_q;
	logic [AW-1:0]       c_q;
	logic                x_end, y_end, it_end;

	assign wh = {{YW{1'b0}}, w_eff} * {{XW{1'b0}}, h_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			clr_n_q <= '0;
		end else if (cmd.clr_start) begin
			clr_q   <= '0;
			clr_n_q <= cmd.clr_full ? CW'(DEPTH) : CW'(wh);
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + CW'(1);
		end
	end

	assign x_end  = x_q == w_m2;
	assign y_end  = y_q == h_m2;
	assign it_end = iter_q == iter_cnt_q - ITER_REG_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			x_q    <= '0;
			y_q    <= '0;
			c_q    <= '0;
		end else if (cmd.sweep_start) begin
			iter_q <= '0;
			x_q    <= XW'(1);
			y_q    <= YW'(1);
			c_q    <= h_aw + AW'(1);
		end else if (cmd.cell_next) begin
			if (y_end) begin
				y_q <= YW'(1);
				if (x_end) begin
					x_q    <= XW'(1);
					c_q    <= h_aw + AW'(1);
					iter_q <= iter_q + ITER_REG_W'(1);
				end else begin
					x_q <= x_q + XW'(1);
					c_q <= c_q + AW'(3);
				end
			end else begin
				y_q <= y_q + YW'(1);
				c_q <= c_q + AW'(1);
			end
		end
	end

	logic [AW-1:0] c_l, c_r, c_b, c_t, rd_addr;

	assign c_l = c_q - h_aw;
	assign c_r = c_q + h_aw;
	assign c_b = c_q - AW'(1);
	assign c_t = c_q + AW'(1);

	always_comb begin
		if (cmd.rd_req) begin
			rd_addr = addr_idx;
		end else begin
			case (cmd.rd_sel)
				NB_L:    rd_addr = c_l;
				NB_R:    rd_addr = c_r;
				NB_B:    rd_addr = c_b;
				NB_T:    rd_addr = c_t;
				default: rd_addr = c_q;
			endcase
		end
	end

	// cell memories
	logic signed [DATA_W-1:0] vx_rd, vy_rd, p_rd, d_rd;
	logic                     o_rd;
	logic [KIND_W-1:0]        k_rd;
	logic                     vx_we, vy_we, p_we, ld_we;
	logic [AW-1:0]            vx_wa, vy_wa, p_wa;
	logic signed [DATA_W-1:0] vx_wd, vy_wd, p_wd;
	logic signed [DATA_W-1:0] p_new, vxc_new, vyc_new, vxr_new, vyt_new;
	logic                     open_l_q, open_r_q, open_b_q, open_t_q;

	assign ld_we = cmd.load_wr && idx_ok;
	assign vx_we = ld_we || (cmd.wr1 && open_l_q) || (cmd.wr2 && open_r_q);
	assign vy_we = ld_we || (cmd.wr1 && open_b_q) || (cmd.wr2 && open_t_q);
	assign p_we  = cmd.clr_wr || cmd.wr1;
	assign vx_wa = cmd.load_wr ? addr_idx : (cmd.wr2 ? c_r : c_q);
	assign vy_wa = cmd.load_wr ? addr_idx : (cmd.wr2 ? c_t : c_q);
	assign p_wa  = cmd.clr_wr ? AW'(clr_q) : c_q;
	assign vx_wd = cmd.load_wr ? vxin_q : (cmd.wr2 ? vxr_new : vxc_new);
	assign vy_wd = cmd.load_wr ? vyin_q : (cmd.wr2 ? vyt_new : vyc_new);
	assign p_wd  = cmd.clr_wr ? '0 : p_new;

	pps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_vx_ram (
		.clk(clk), .we(vx_we), .waddr(vx_wa), .wdata(vx_wd), .raddr(rd_addr), .rdata(vx_rd)
	);
	pps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_vy_ram (
		.clk(clk), .we(vy_we), .waddr(vy_wa), .wdata(vy_wd), .raddr(rd_addr), .rdata(vy_rd)
	);
	pps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_p_ram (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(rd_addr), .rdata(p_rd)
	);
	pps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_d_ram (
		.clk(clk), .we(ld_we), .waddr(addr_idx), .wdata(densin_q), .raddr(rd_addr),
		.rdata(d_rd)
	);
	pps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_o_ram (
		.clk(clk), .we(ld_we), .waddr(addr_idx), .wdata(openin_q), .raddr(rd_addr),
		.rdata(o_rd)
	);
	pps_ram #(.WIDTH(KIND_W), .DEPTH(DEPTH)) u_k_ram (
		.clk(clk), .we(ld_we), .waddr(addr_idx), .wdata(kindin_q), .raddr(rd_addr),
		.rdata(k_rd)
	);

	// neighbourhood capture
	logic [KIND_W-1:0]        kind_c_q;
	logic signed [DATA_W-1:0] dens_c_q, p_c_q, vxc_q, vyc_q, vxr_q, vyt_q;
	logic [2:0]               s_cnt;

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			case (cmd.cap_sel)
				NB_C: begin
					kind_c_q <= k_rd;
					dens_c_q <= d_rd;
					p_c_q    <= p_rd;
					vxc_q    <= vx_rd;
					vyc_q    <= vy_rd;
				end
				NB_L: open_l_q <= o_rd;
				NB_R: begin
					open_r_q <= o_rd;
					vxr_q    <= vx_rd;
				end
				NB_B: open_b_q <= o_rd;
				NB_T: begin
					open_t_q <= o_rd;
					vyt_q    <= vy_rd;
				end
				default: ;
			endcase
		end
	end

	assign s_cnt = {2'b00, open_l_q} + {2'b00, open_r_q} + {2'b00, open_b_q}
		+ {2'b00, open_t_q};

	// cell update arithmetic
	logic signed [34:0] div_d, div_q, excess;
	logic [34:0]        mag_q;
	logic               neg_q;
	logic [52:0]        prod;
	logic [QW-1:0]      dq_q, dq_neg;
	logic [2:0]         rem_q;
	logic [3:0]         rem_tmp;
	logic               rem_ge;
	logic [DCW-1:0]     dcnt_q;
	logic signed [DATA_W-1:0] corr_q;
	logic signed [63:0] pprod_q;
	logic signed [47:0] dp_q;

	assign excess = 35'(dens_c_q) - $signed({4'b0000, rest_q});
	assign div_d  = 35'(vxr_q) - 35'(vxc_q) + 35'(vyt_q) - 35'(vyc_q)
		- (((rest_q != '0) && (excess > 0)) ? excess : 35'sd0);
	assign prod    = mag_q * ovr_q;
	assign rem_tmp = {rem_q, dq_q[QW-1]};
	assign rem_ge  = rem_tmp >= {1'b0, s_cnt};
	assign dq_neg  = -dq_q;

	always_ff @(posedge clk) begin
		if (cmd.calc_div) begin
			div_q <= div_d;
		end
		if (cmd.calc_abs) begin
			neg_q <= div_q > 0;
			mag_q <= (div_q < 0) ? 35'(-div_q) : 35'(div_q);
		end
		if (cmd.mul) begin
			dq_q  <= (|prod[52:50]) ? {QW{1'b1}} : prod[49:16];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[QW-2:0], rem_ge};
			rem_q <= rem_ge ? 3'(rem_tmp - {1'b0, s_cnt}) : rem_tmp[2:0];
		end
		if (cmd.corr_calc) begin
			if (neg_q) begin
				corr_q <= (dq_q >= QW'(34'h080000000)) ? 32'sh80000000 : dq_neg[31:0];
			end else begin
				corr_q <= (dq_q >= QW'(34'h080000000)) ? 32'sh7FFFFFFF : dq_q[31:0];
			end
		end
		if (cmd.pmul) begin
			pprod_q <= $signed({1'b0, pscale_q}) * corr_q;
		end
		if (cmd.pshift) begin
			dp_q <= (pprod_q < 0) ? 48'((pprod_q + 64'sd65535) >>> 16) : 48'(pprod_q >>> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.mul) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	assign p_new   = sat32(50'(p_c_q) + 50'(dp_q));
	assign vxc_new = sat32(50'(vxc_q) - 50'(corr_q));
	assign vyc_new = sat32(50'(vyc_q) - 50'(corr_q));
	assign vxr_new = sat32(50'(vxr_q) + 50'(corr_q));
	assign vyt_new = sat32(50'(vyt_q) + 50'(corr_q));

	// result register
	logic                     out_valid_q, out_kind_q;
	logic signed [DATA_W-1:0] out_p_q, out_vx_q, out_vy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.read_out || cmd.fin_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_out) begin
			out_kind_q <= RES_READ;
			out_p_q    <= idx_ok ? p_rd  : '0;
			out_vx_q   <= idx_ok ? vx_rd : '0;
			out_vy_q   <= idx_ok ? vy_rd : '0;
		end else if (cmd.fin_out) begin
			out_kind_q <= RES_SOLVE;
			out_p_q    <= '0;
			out_vx_q   <= '0;
			out_vy_q   <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = {out_vy_q, out_vx_q, out_p_q};

	// status
	assign st.clr_last    = clr_q == clr_n_q - CW'(1);
	assign st.clr_empty   = clr_n_q == '0;
	assign st.sweep_empty = (iter_cnt_q == '0) || (w_eff < XW'(3)) || (h_eff < YW'(3));
	assign st.cell_last   = y_end && x_end && it_end;
	assign st.skip        = (kind_c_q != KIND_FLUID) || (s_cnt == 3'd0);
	assign st.div_last    = dcnt_q == DCW'(QW - 1);
	assign st.out_free    = !out_valid_q || out_ready;

endmodule

/* tb/sv/pressure_projection_checker.sv */
// ----------------------------------------------------------------------------
// pressure_projection_checker
// Watches the request, result and register channels of the solver, keeps its
// own copy of the cell memory and registers, predicts every result and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pressure_projection_checker import pps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	input  logic                   s_ready,
	input  logic [IN_TDATA_W-1:0]  s_data,
	input  logic [OP_W-1:0]        s_user,
	input  logic                   m_valid,
	input  logic                   m_ready,
	input  logic [OUT_TDATA_W-1:0] m_data,
	input  logic                   m_user,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                     pending,
	output int                     fails
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_MAX = 32;
	localparam int DEPTH    = GRID_MAX * GRID_MAX;

	typedef struct packed {
		logic        kind;
		logic [31:0] pressure;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
	} cell_result_t;

	logic signed [31:0] vx_mem [DEPTH];
	logic signed [31:0] vy_mem [DEPTH];
	logic signed [31:0] pr_mem [DEPTH];
	logic signed [31:0] dn_mem [DEPTH];
	logic               op_mem [DEPTH];
	logic [KIND_W-1:0]  kd_mem [DEPTH];

	logic [GRID_REG_W-1:0]  grid_w;
	logic [GRID_REG_W-1:0]  grid_h;
	logic [ITER_REG_W-1:0]  sweeps;
	logic [OVR_REG_W-1:0]   relax_factor;
	logic [SCALE_REG_W-1:0] p_scale;
	logic [SCALE_REG_W-1:0] rest_dens;

	cell_result_t result_q[$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	task automatic relax_cell(int c, int h);
		int     l, r, b, t;
		longint s, dv, excess, corr;
		l = c - h;
		r = c + h;
		b = c - 1;
		t = c + 1;
		s = op_mem[l] + op_mem[r] + op_mem[b] + op_mem[t];
		if (s == 0)
			return;
		dv = (longint'(vx_mem[r]) - vx_mem[c]) + (longint'(vy_mem[t]) - vy_mem[c]);
		if (rest_dens != 0) begin
			excess = longint'(dn_mem[c]) - longint'(rest_dens);
			if (excess > 0)
				dv -= excess;
		end
		corr = clamp32((-dv * longint'(relax_factor)) / (s * 65536));
		pr_mem[c] = clamp32(longint'(pr_mem[c]) + (longint'(p_scale) * corr) / 65536);
		if (op_mem[l]) vx_mem[c] = clamp32(longint'(vx_mem[c]) - corr);
		if (op_mem[r]) vx_mem[r] = clamp32(longint'(vx_mem[r]) + corr);
		if (op_mem[b]) vy_mem[c] = clamp32(longint'(vy_mem[c]) - corr);
		if (op_mem[t]) vy_mem[t] = clamp32(longint'(vy_mem[t]) + corr);
	endtask

	task automatic project_pressure();
		int w, h;
		w = (grid_w > GRID_MAX) ? GRID_MAX : grid_w;
		h = (grid_h > GRID_MAX) ? GRID_MAX : grid_h;
		for (int i = 0; i < w * h; i++)
			pr_mem[i] = '0;
		for (int it = 0; it < sweeps; it++)
			for (int x = 1; x + 1 < w; x++)
				for (int y = 1; y + 1 < h; y++)
					if (kd_mem[x * h + y] == KIND_FLUID)
						relax_cell(x * h + y, h);
	endtask

	initial begin
		fails = 0;
		pending = 0;
		for (int i = 0; i < DEPTH; i++) begin
			vx_mem[i] = '0;
			vy_mem[i] = '0;
			pr_mem[i] = '0;
			dn_mem[i] = '0;
			op_mem[i] = '0;
			kd_mem[i] = '0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		cell_result_t got, want;
		int           idx;
		if (!arst_n) begin
			grid_w       = 6'd32;
			grid_h       = 6'd32;
			sweeps       = 8'd40;
			relax_factor = 18'd124518;
			p_scale      = 31'd65536;
			rest_dens    = '0;
		end else begin
			if (m_valid && m_ready) begin
				got = {m_user, m_data[31:0], m_data[63:32], m_data[95:64]};
				if (result_q.size() == 0) begin
					$display("%0t: result with none expected: %h", $time, got);
					fails++;
				end else begin
					want = result_q.pop_front();
					if (got.kind !== want.kind) begin
						$display("%0t: result_kind expected %0d got %0d", $time,
							want.kind, got.kind);
						fails++;
					end
					if (got.pressure !== want.pressure) begin
						$display("%0t: pressure_out expected %h got %h", $time,
							want.pressure, got.pressure);
						fails++;
					end
					if (got.vel_x !== want.vel_x) begin
						$display("%0t: velocity_x_out expected %h got %h", $time,
							want.vel_x, got.vel_x);
						fails++;
					end
					if (got.vel_y !== want.vel_y) begin
						$display("%0t: velocity_y_out expected %h got %h", $time,
							want.vel_y, got.vel_y);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRID_WIDTH:      grid_w = cfg_wdata[GRID_REG_W-1:0];
					CFG_GRID_HEIGHT:     grid_h = cfg_wdata[GRID_REG_W-1:0];
					CFG_ITERATION_COUNT: sweeps = cfg_wdata[ITER_REG_W-1:0];
					CFG_OVER_RELAXATION: relax_factor = cfg_wdata[OVR_REG_W-1:0];
					CFG_PRESSURE_SCALE:  p_scale = cfg_wdata[SCALE_REG_W-1:0];
					CFG_REST_DENSITY:    rest_dens = cfg_wdata[SCALE_REG_W-1:0];
					default: ;
				endcase
			end
			if (s_valid && s_ready) begin
				idx = s_data[9:0];
				case (op_t'(s_user))
					OP_LOAD: begin
						vx_mem[idx] = s_data[41:10];
						vy_mem[idx] = s_data[73:42];
						dn_mem[idx] = s_data[105:74];
						op_mem[idx] = s_data[106];
						kd_mem[idx] = s_data[108:107];
					end
					OP_SOLVE: begin
						project_pressure();
						result_q.push_back({RES_SOLVE, 96'd0});
					end
					OP_READ:
						result_q.push_back({RES_READ, pr_mem[idx], vx_mem[idx], vy_mem[idx]});
					default: ;
				endcase
			end
			pending = result_q.size();
		end
	end

endmodule

/* tb/sv/pressure_projection_solver_tb.sv */
// ----------------------------------------------------------------------------
// pressure_projection_solver_tb
// Drives load, solve and read requests and register writes into the solver
// under random source gaps and sink stalls; a checker beside the block
// predicts and compares the results, this module gives the verdict.
// ----------------------------------------------------------------------------
module pressure_projection_solver_tb import pps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                IDLE_LIMIT  = 200000;
	localparam int                ITEM_TARGET = 850;
	localparam logic [KIND_W-1:0] KIND_SOLID  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_AIR    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_valid = 1'b0;
	logic                   s_ready;
	logic [IN_TDATA_W-1:0]  s_data = '0;
	logic [OP_W-1:0]        s_user = '0;
	logic                   m_valid;
	logic                   m_ready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_data;
	logic                   m_user;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	int                     pending;
	int                     fails;

	int src_gap = 13;
	int sink_stall = 48;
	int hold_cycles = 0;
	int items = 0;
	int idle_cnt = 0;
	int w_eff = 32;
	int h_eff = 32;
	bit written [1024];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pressure_projection_solver u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	pressure_projection_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_valid),
		.s_ready   (s_ready),
		.s_data    (s_data),
		.s_user    (s_user),
		.m_valid   (m_valid),
		.m_ready   (m_ready),
		.m_data    (m_data),
		.m_user    (m_user),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.fails     (fails)
	);

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			m_ready = 1'b0;
		end else begin
			m_ready = ($urandom_range(99) >= sink_stall);
		end
	end

	always @(posedge clk) begin
		if ((s_valid && s_ready) || (m_valid && m_ready))
			idle_cnt = 0;
		else
			idle_cnt = idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("pressure_projection_solver test failed");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3, 4: return $urandom_range(131071) - 65536;
			5: return $urandom;
			default: return $urandom_range(2097151) - 1048576;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		if ($urandom_range(9) < 6)
			return KIND_FLUID;
		return $urandom_range(3);
	endfunction

	task automatic send(logic [OP_W-1:0] op, int idx, logic [31:0] vx, logic [31:0] vy,
			logic [31:0] dn, logic open, logic [KIND_W-1:0] kind);
		while ($urandom_range(99) < src_gap) begin
			s_valid = 1'b0;
			@(negedge clk);
		end
		s_valid = 1'b1;
		s_user = op;
		s_data = '0;
		s_data[108:0] = {kind, open, dn, vy, vx, idx[9:0]};
		if (op == OP_LOAD)
			written[idx] = 1'b1;
		items++;
		do @(posedge clk); while (!s_ready);
		@(negedge clk);
	endtask

	task automatic load_cell(int idx);
		send(OP_LOAD, idx, pick_value(), pick_value(), pick_value(),
			$urandom_range(9) < 8, pick_kind());
	endtask

	task automatic read_cell();
		int idx;
		do idx = $urandom_range(1023); while (!written[idx]);
		send(OP_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic drain();
		s_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int w, int h, int iters, int ovr, int scale, int rest);
		drain();
		write_reg(CFG_GRID_WIDTH, w);
		write_reg(CFG_GRID_HEIGHT, h);
		write_reg(CFG_ITERATION_COUNT, iters);
		write_reg(CFG_OVER_RELAXATION, ovr);
		write_reg(CFG_PRESSURE_SCALE, scale);
		write_reg(CFG_REST_DENSITY, rest);
		w_eff = (w > 32) ? 32 : w;
		h_eff = (h > 32) ? 32 : h;
	endtask

	task automatic fill_grid();
		for (int i = 0; i < w_eff * h_eff; i++)
			if (!written[i])
				load_cell(i);
	endtask

	task automatic set_idling();
		if (items < 300) begin
			src_gap = 13;
			sink_stall = 48;
		end else if (items < 600) begin
			src_gap = 48;
			sink_stall = 13;
		end else begin
			src_gap = 0;
			sink_stall = 0;
		end
	endtask

	initial begin
		int w, h, phase;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: single interior cell, extreme factors, all kinds around it
		configure(3, 3, 255, 131072, 31'h7fffffff, 0);
		send(OP_LOAD, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1, KIND_SOLID);
		send(OP_LOAD, 1, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, KIND_AIR);
		send(OP_LOAD, 2, 32'h0, 32'h10000, 32'h0, 1'b1, KIND_SPARE);
		send(OP_LOAD, 3, 32'h10000, 32'hffff0000, 32'h20000, 1'b1, KIND_FLUID);
		send(OP_LOAD, 4, 32'h8000, 32'h18000, 32'h30000, 1'b1, KIND_FLUID);
		send(OP_LOAD, 5, 32'h7fffffff, 32'h7fffffff, 32'h0, 1'b1, KIND_SOLID);
		send(OP_LOAD, 6, 32'h80000000, 32'h80000000, 32'h0, 1'b0, KIND_AIR);
		send(OP_LOAD, 7, 32'h0, 32'h7fffffff, 32'h0, 1'b1, KIND_FLUID);
		send(OP_LOAD, 8, 32'hffffffff, 32'h1, 32'h0, 1'b0, KIND_SPARE);
		send(OP_LOAD, 1023, 32'h5555aaaa, 32'haaaa5555, 32'hffffffff, 1'b1, KIND_SPARE);
		send(OP_UNUSED, 1023, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_SOLVE, 0, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_READ, 4, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_READ, 7, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_READ, 5, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_READ, 1023, '0, '0, '0, 1'b0, KIND_FLUID);
		// centre cell isolated by closed all-zero neighbours, compression term on
		configure(3, 3, 3, 0, 0, 31'h7fffffff);
		send(OP_LOAD, 1, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_LOAD, 3, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_LOAD, 5, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_LOAD, 7, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_SOLVE, 0, '0, '0, '0, 1'b0, KIND_FLUID);
		send(OP_READ, 4, '0, '0, '0, 1'b0, KIND_FLUID);
		// oversized and narrow grid registers
		configure(63, 3, 1, 124518, 65536, 65536);
		fill_grid();
		send(OP_SOLVE, 0, '0, '0, '0, 1'b0, KIND_FLUID);
		configure(2, 63, 2, 65536, 65536, 0);
		fill_grid();
		send(OP_SOLVE, 0, '0, '0, '0, 1'b0, KIND_FLUID);
		read_cell();

		phase = 0;
		while (items < ITEM_TARGET) begin
			if ($urandom_range(7) == 0) begin
				if ($urandom_range(1)) begin
					w = $urandom_range(63);
					h = $urandom_range(6);
				end else begin
					w = $urandom_range(6);
					h = $urandom_range(63);
				end
				configure(w, h, $urandom_range(1), $urandom_range(131072),
					$urandom & 31'h7fffffff,
					$urandom_range(1) ? 0 : ($urandom & 31'h7fffffff));
			end else begin
				configure($urandom_range(3, 7), $urandom_range(3, 7), $urandom_range(6),
					$urandom_range(131072),
					$urandom_range(1) ? $urandom_range(262144) : ($urandom & 31'h7fffffff),
					$urandom_range(1) ? 0 : $urandom_range(262144));
			end
			set_idling();
			fill_grid();
			if (phase == 3) begin
				hold_cycles = 400;
				repeat (6) read_cell();
			end
			repeat ($urandom_range(15, 35)) begin
				case ($urandom_range(19))
					0, 1: send(OP_SOLVE, $urandom_range(1023), $urandom, $urandom, $urandom,
						$urandom, $urandom);
					2: send(OP_UNUSED, $urandom_range(1023), $urandom, $urandom, $urandom,
						$urandom, $urandom);
					3: load_cell($urandom_range(1023));
					4, 5, 6, 7, 8, 9: load_cell($urandom_range(w_eff * h_eff > 0 ?
						w_eff * h_eff - 1 : 0));
					default: read_cell();
				endcase
				set_idling();
			end
			send(OP_SOLVE, 0, '0, '0, '0, 1'b0, KIND_FLUID);
			repeat (3) read_cell();
			phase++;
		end

		drain();
		repeat (50) @(negedge clk);
		if (fails == 0)
			$display("pressure_projection_solver test passed");
		else
			$display("pressure_projection_solver test failed");
		$finish;
	end

endmodule
